// File: design/rotate_then_move_goal_controller_macros.svh
// Assertion macros shared by the goal controller modules.
// Included by rtmgc_cordic and rtmgc_ctrl; depends on nothing else.
`ifndef ROTATE_THEN_MOVE_GOAL_CONTROLLER_MACROS_SVH
`define ROTATE_THEN_MOVE_GOAL_CONTROLLER_MACROS_SVH
`ifndef SYNTHESIS
`define RTMGC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RTMGC_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define RTMGC_ASSERT(lbl, clk, rst_n, prop, msg)
`define RTMGC_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

// File: design/rtmgc_pkg.sv
// Shared types and constants of the goal controller.
// Used by rtmgc_cordic, rtmgc_ctrl and the top level; no dependencies.
package rtmgc_pkg;

    // CORDIC working widths: lengths * 256, angles in rad * 2^24
    localparam int XW       = 28;
    localparam int ZW       = 28;
    localparam int TAB_IW   = 5;
    localparam int PW       = 43;

    localparam logic signed [ZW-1:0] HALF_PI_Z = 28'sd26353589;
    localparam logic [15:0]          INV_GAIN  = 16'd39797;

    // register indexes on the configuration port
    localparam logic [1:0] CFG_ARRIVE_RADIUS   = 2'd0;
    localparam logic [1:0] CFG_ANGLE_TOLERANCE = 2'd1;
    localparam logic [1:0] CFG_STOP_TICKS      = 2'd2;

    typedef struct packed {
        logic start;
    } t_dp_cmd;

    typedef struct packed {
        logic busy;
        logic done;
        logic near;      // distance below arrival radius
        logic aligned;   // |bearing| below tolerance
        logic yaw_off;   // |goal yaw| at or above tolerance
    } t_dp_status;

    function automatic logic [ZW-1:0] atan_lut(input logic [TAB_IW-1:0] idx);
        logic [ZW-1:0] v;
        case (idx)
            5'd0:    v = 28'd13176795;
            5'd1:    v = 28'd7778716;
            5'd2:    v = 28'd4110060;
            5'd3:    v = 28'd2086331;
            5'd4:    v = 28'd1047214;
            5'd5:    v = 28'd524117;
            5'd6:    v = 28'd262123;
            5'd7:    v = 28'd131069;
            5'd8:    v = 28'd65536;
            5'd9:    v = 28'd32768;
            5'd10:   v = 28'd16384;
            5'd11:   v = 28'd8192;
            5'd12:   v = 28'd4096;
            5'd13:   v = 28'd2048;
            5'd14:   v = 28'd1024;
            5'd15:   v = 28'd512;
            5'd16:   v = 28'd256;
            5'd17:   v = 28'd128;
            5'd18:   v = 28'd64;
            5'd19:   v = 28'd32;
            5'd20:   v = 28'd16;
            5'd21:   v = 28'd8;
            5'd22:   v = 28'd4;
            5'd23:   v = 28'd2;
            default: v = 28'd0;
        endcase
        return v;
    endfunction

endpackage

// File: design/rtmgc_cordic.sv
// Datapath: iterative vectoring CORDIC giving distance and bearing, plus
// the threshold compares and speed candidates. Depends on rtmgc_pkg.
`include "rotate_then_move_goal_controller_macros.svh"
module rtmgc_cordic #(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  rtmgc_pkg::t_dp_cmd      i_cmd,
    input  logic signed [15:0]      i_goal_x,
    input  logic signed [15:0]      i_goal_y,
    input  logic signed [15:0]      i_goal_yaw,
    input  logic [15:0]             i_arrive_radius,
    input  logic [14:0]             i_angle_tolerance,
    output rtmgc_pkg::t_dp_status   o_status,
    output logic [15:0]             o_lin_move,
    output logic signed [16:0]      o_ang_dir,
    output logic signed [16:0]      o_ang_yaw
);
    localparam int XW = rtmgc_pkg::XW;
    localparam int ZW = rtmgc_pkg::ZW;
    localparam int PW = rtmgc_pkg::PW;
    localparam int IW = rtmgc_pkg::TAB_IW;
    localparam logic [IW-1:0] LAST_ITER = IW'(CORDIC_ITERATIONS - 1);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_ITER = 2'd1;
    localparam logic [1:0] PH_MUL  = 2'd2;
    localparam logic [1:0] PH_DONE = 2'd3;

    logic [1:0]            r_phase, n_phase;
    logic [IW-1:0]         r_iter, n_iter;
    logic signed [XW-1:0]  r_x, n_x, r_y, n_y;
    logic signed [ZW-1:0]  r_z, n_z;
    logic [PW-1:0]         r_prod, n_prod;
    logic signed [15:0]    r_yaw, n_yaw;
    logic                  r_origin, n_origin;

    logic signed [XW-1:0]  gx_s, gy_s, dx, dy;
    logic signed [ZW-1:0]  atan_i;
    logic [XW-2:0]         x_pos;
    logic [PW:0]           dist_sum;
    logic signed [ZW-1:0]  dir_sum;
    logic [16:0]           dist_val;
    logic signed [16:0]    dir;
    logic [16:0]           abs_dir, abs_yaw;
    logic [17:0]           lin2;

    always_comb begin
        gx_s   = {{4{i_goal_x[15]}}, i_goal_x, 8'b0};
        gy_s   = {{4{i_goal_y[15]}}, i_goal_y, 8'b0};
        dx     = r_y >>> r_iter;
        dy     = r_x >>> r_iter;
        atan_i = signed'(rtmgc_pkg::atan_lut(r_iter));
        x_pos  = r_x[XW-1] ? '0 : r_x[XW-2:0];

        n_phase  = r_phase;
        n_iter   = r_iter;
        n_x      = r_x;
        n_y      = r_y;
        n_z      = r_z;
        n_prod   = r_prod;
        n_yaw    = r_yaw;
        n_origin = r_origin;

        if (i_cmd.start) begin
            n_phase  = PH_ITER;
            n_iter   = '0;
            n_yaw    = i_goal_yaw;
            n_origin = (i_goal_x == 16'sd0) && (i_goal_y == 16'sd0);
            // left half plane: pre-rotate by a quarter turn
            if (i_goal_x[15]) begin
                if (!i_goal_y[15]) begin
                    n_x = gy_s;
                    n_y = -gx_s;
                    n_z = rtmgc_pkg::HALF_PI_Z;
                end else begin
                    n_x = -gy_s;
                    n_y = gx_s;
                    n_z = -rtmgc_pkg::HALF_PI_Z;
                end
            end else begin
                n_x = gx_s;
                n_y = gy_s;
                n_z = '0;
            end
        end else begin
            case (r_phase)
                PH_ITER: begin
                    if (!r_y[XW-1]) begin
                        n_x = r_x + dx;
                        n_y = r_y - dy;
                        n_z = r_z + atan_i;
                    end else begin
                        n_x = r_x - dx;
                        n_y = r_y + dy;
                        n_z = r_z - atan_i;
                    end
                    n_iter = r_iter + 1'b1;
                    if (r_iter == LAST_ITER) begin
                        n_phase = PH_MUL;
                    end
                end
                PH_MUL: begin
                    n_prod  = PW'(x_pos) * PW'(rtmgc_pkg::INV_GAIN);
                    n_phase = PH_DONE;
                end
                PH_DONE: begin
                    n_phase = PH_IDLE;
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
        end else begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_iter   <= n_iter;
        r_x      <= n_x;
        r_y      <= n_y;
        r_z      <= n_z;
        r_prod   <= n_prod;
        r_yaw    <= n_yaw;
        r_origin <= n_origin;
    end

    // results stay put after done until the next start
    always_comb begin
        dist_sum = {1'b0, r_prod} + (PW+1)'(1 << 23);
        dir_sum  = r_z + ZW'(1024);
        dist_val = r_origin ? 17'd0 : dist_sum[40:24];
        dir      = r_origin ? 17'sd0 : dir_sum[ZW-1:11];
        abs_dir  = dir[16] ? 17'(-dir) : 17'(dir);
        abs_yaw  = r_yaw[15] ? 17'(-{r_yaw[15], r_yaw}) : {1'b0, r_yaw};
        lin2     = {dist_val, 1'b0};

        o_status.busy    = (r_phase != PH_IDLE);
        o_status.done    = (r_phase == PH_DONE);
        o_status.near    = (dist_val < {1'b0, i_arrive_radius});
        o_status.aligned = (abs_dir < {2'b0, i_angle_tolerance});
        o_status.yaw_off = (abs_yaw >= {2'b0, i_angle_tolerance});

        o_lin_move = (lin2 > 18'd65535) ? 16'hFFFF : lin2[15:0];
        o_ang_dir  = {dir[15:0], 1'b0};
        o_ang_yaw  = {r_yaw[15], r_yaw};
    end

    `RTMGC_ASSERT(a_done_after_mul, i_clk, i_rst_n, o_status.done |-> $past(r_phase == PH_MUL), "CORDIC done without scaling step")

endmodule

// File: design/rtmgc_ctrl.sv
// Controller: request handshakes, stop phase, ROTATE/MOVE state machine and
// the output register. Drives rtmgc_cordic via t_dp_cmd; depends on rtmgc_pkg.
`include "rotate_then_move_goal_controller_macros.svh"
module rtmgc_ctrl (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s_tvalid,
    output logic                    o_s_tready,
    input  logic                    i_command,
    input  logic                    i_transform_ok,
    input  logic [3:0]              i_stop_ticks,
    output rtmgc_pkg::t_dp_cmd      o_cmd,
    input  rtmgc_pkg::t_dp_status   i_status,
    input  logic [15:0]             i_lin_move,
    input  logic signed [16:0]      i_ang_dir,
    input  logic signed [16:0]      i_ang_yaw,
    output logic                    o_m_tvalid,
    input  logic                    i_m_tready,
    output logic [15:0]             o_linear_speed,
    output logic signed [16:0]      o_angular_speed
);
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_CORDIC = 2'd1;
    localparam logic [1:0] ST_EMIT   = 2'd2;

    localparam logic [1:0] SEL_ZERO = 2'd0;
    localparam logic [1:0] SEL_YAW  = 2'd1;
    localparam logic [1:0] SEL_TURN = 2'd2;
    localparam logic [1:0] SEL_MOVE = 2'd3;

    localparam logic MODE_ROTATE = 1'b0;
    localparam logic MODE_MOVE   = 1'b1;

    logic [1:0]         r_state, n_state;
    logic [1:0]         r_sel, n_sel;
    logic               r_mode, n_mode;
    logic               r_stop_pending, n_stop_pending;
    logic               r_goal_held, n_goal_held;
    logic [3:0]         r_stop_cnt, n_stop_cnt;
    logic               r_m_valid, n_m_valid;
    logic [15:0]        r_m_lin, n_m_lin;
    logic signed [16:0] r_m_ang, n_m_ang;

    logic               accept;
    logic               m_free;
    logic [4:0]         cnt_inc;

    always_comb begin
        o_s_tready  = (r_state == ST_IDLE);
        accept      = i_s_tvalid && o_s_tready;
        m_free      = !r_m_valid || i_m_tready;
        cnt_inc     = {1'b0, r_stop_cnt} + 5'd1;
        o_cmd.start = 1'b0;

        n_state        = r_state;
        n_sel          = r_sel;
        n_mode         = r_mode;
        n_stop_pending = r_stop_pending;
        n_goal_held    = r_goal_held;
        n_stop_cnt     = r_stop_cnt;
        n_m_valid      = r_m_valid && !i_m_tready;
        n_m_lin        = r_m_lin;
        n_m_ang        = r_m_ang;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (!i_command) begin
                        n_stop_pending = 1'b1;
                        n_goal_held    = 1'b1;
                    end else if (r_stop_pending) begin
                        // compare before the 4-bit store so 15 still ends
                        if (cnt_inc > {1'b0, i_stop_ticks}) begin
                            n_mode         = MODE_ROTATE;
                            n_stop_pending = 1'b0;
                            n_stop_cnt     = 4'd0;
                        end else begin
                            n_stop_cnt = cnt_inc[3:0];
                        end
                        n_sel   = SEL_ZERO;
                        n_state = ST_EMIT;
                    end else if (r_goal_held && i_transform_ok) begin
                        o_cmd.start = 1'b1;
                        n_state     = ST_CORDIC;
                    end
                end
            end
            ST_CORDIC: begin
                if (i_status.done) begin
                    if (r_mode == MODE_ROTATE) begin
                        if (i_status.near) begin
                            n_sel = i_status.yaw_off ? SEL_YAW : SEL_ZERO;
                        end else if (i_status.aligned) begin
                            n_mode = MODE_MOVE;
                            n_sel  = SEL_ZERO;
                        end else begin
                            n_sel = SEL_TURN;
                        end
                    end else begin
                        if (i_status.near) begin
                            n_mode = MODE_ROTATE;
                            n_sel  = SEL_ZERO;
                        end else begin
                            n_sel = SEL_MOVE;
                        end
                    end
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (m_free) begin
                    n_m_valid = 1'b1;
                    case (r_sel)
                        SEL_YAW: begin
                            n_m_lin = 16'd0;
                            n_m_ang = i_ang_yaw;
                        end
                        SEL_TURN: begin
                            n_m_lin = 16'd0;
                            n_m_ang = i_ang_dir;
                        end
                        SEL_MOVE: begin
                            n_m_lin = i_lin_move;
                            n_m_ang = i_ang_dir;
                        end
                        default: begin
                            n_m_lin = 16'd0;
                            n_m_ang = 17'sd0;
                        end
                    endcase
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_mode         <= MODE_ROTATE;
            r_stop_pending <= 1'b0;
            r_goal_held    <= 1'b0;
            r_stop_cnt     <= 4'd0;
            r_m_valid      <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_mode         <= n_mode;
            r_stop_pending <= n_stop_pending;
            r_goal_held    <= n_goal_held;
            r_stop_cnt     <= n_stop_cnt;
            r_m_valid      <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sel   <= n_sel;
        r_m_lin <= n_m_lin;
        r_m_ang <= n_m_ang;
    end

    assign o_m_tvalid      = r_m_valid;
    assign o_linear_speed  = r_m_lin;
    assign o_angular_speed = r_m_ang;

    `RTMGC_ASSERT(a_start_idle, i_clk, i_rst_n, o_cmd.start |-> !i_status.busy, "CORDIC started while busy")
    `RTMGC_ASSERT(a_done_in_wait, i_clk, i_rst_n, i_status.done |-> (r_state == ST_CORDIC), "CORDIC done outside wait state")
    `RTMGC_ASSERT(a_cnt_pending, i_clk, i_rst_n, (r_stop_cnt != 4'd0) |-> r_stop_pending, "stop counter live outside stop phase")
    `RTMGC_ASSERT(a_emit_loads, i_clk, i_rst_n, ((r_state == ST_EMIT) && m_free) |=> r_m_valid, "result not loaded into output register")

endmodule

// File: design/rotate_then_move_goal_controller.sv
// Turn-then-drive go-to-goal controller. A request with tuser[0] = 0 announces a
// new goal and gives no result. A tick (tuser[0] = 1) gives at most one result:
// during the stop phase after a new goal it is (0,0), passing through ST_EMIT into
// the output register; otherwise, with a goal held and tuser[1] (transform ok)
// set, distance and bearing come from an iterative CORDIC doing one
// micro-rotation per cycle, and the next request is taken once its result is in the
// output register. Ticks with no goal or a failed transform are dropped.
// Configuration is written through i_cfg_we/i_cfg_idx/i_cfg_data.
// Depends on rtmgc_pkg, rtmgc_cordic and rtmgc_ctrl.
module rotate_then_move_goal_controller #(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [15:0] goal_x, [31:16] goal_y, [47:32] goal_yaw
    input  logic [47:0] i_s_axis_tdata,
    // [0] command, [1] transform_ok
    input  logic [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [15:0] linear_speed, [32:16] angular_speed, [39:33] zero
    output logic [39:0] o_m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    logic [15:0]            r_arrive_radius;
    logic [14:0]            r_angle_tolerance;
    logic [3:0]             r_stop_ticks;

    rtmgc_pkg::t_dp_cmd     dp_cmd;
    rtmgc_pkg::t_dp_status  dp_status;
    logic [15:0]            lin_move;
    logic signed [16:0]     ang_dir;
    logic signed [16:0]     ang_yaw;
    logic [15:0]            linear_speed;
    logic signed [16:0]     angular_speed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arrive_radius   <= 16'd51;
            r_angle_tolerance <= 15'd819;
            r_stop_ticks      <= 4'd7;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rtmgc_pkg::CFG_ARRIVE_RADIUS:   r_arrive_radius   <= i_cfg_data;
                rtmgc_pkg::CFG_ANGLE_TOLERANCE: r_angle_tolerance <= i_cfg_data[14:0];
                rtmgc_pkg::CFG_STOP_TICKS:      r_stop_ticks      <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    rtmgc_cordic #(
        .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
    ) u_cordic (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (dp_cmd),
        .i_goal_x          (i_s_axis_tdata[15:0]),
        .i_goal_y          (i_s_axis_tdata[31:16]),
        .i_goal_yaw        (i_s_axis_tdata[47:32]),
        .i_arrive_radius   (r_arrive_radius),
        .i_angle_tolerance (r_angle_tolerance),
        .o_status          (dp_status),
        .o_lin_move        (lin_move),
        .o_ang_dir         (ang_dir),
        .o_ang_yaw         (ang_yaw)
    );

    rtmgc_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_tvalid      (i_s_axis_tvalid),
        .o_s_tready      (o_s_axis_tready),
        .i_command       (i_s_axis_tuser[0]),
        .i_transform_ok  (i_s_axis_tuser[1]),
        .i_stop_ticks    (r_stop_ticks),
        .o_cmd           (dp_cmd),
        .i_status        (dp_status),
        .i_lin_move      (lin_move),
        .i_ang_dir       (ang_dir),
        .i_ang_yaw       (ang_yaw),
        .o_m_tvalid      (o_m_axis_tvalid),
        .i_m_tready      (i_m_axis_tready),
        .o_linear_speed  (linear_speed),
        .o_angular_speed (angular_speed)
    );

    assign o_m_axis_tdata = {7'b0, angular_speed, linear_speed};

endmodule
